// ===== hdl/tti_pkg.sv =====
// Shared types and constants for the transaction timestamp interval table.
// No dependencies; imported by every other file of the block.
package tti_pkg;

	localparam int STAMP_W = 31;
	localparam int TXN_W = 32;
	localparam int SLOT_W = 6;
	localparam int MODE_W = 4;
	localparam int WIDE_W = 32;
	localparam int QUEUE_DEPTH = 2;
	localparam logic [STAMP_W-1:0] STAMP_TOP = {STAMP_W{1'b1}};
	localparam logic [STAMP_W-1:0] PICK_STEP = STAMP_W'(5);
	localparam logic signed [WIDE_W-1:0] NEG_ONE = {WIDE_W{1'b1}};

	typedef enum logic [MODE_W-1:0] {
		MD_UPD_START = 4'd0,
		MD_UPD_COMMIT = 4'd1,
		MD_FORCE_HIGH = 4'd2,
		MD_FORCE_CLOW = 4'd3,
		MD_CONFLICT = 4'd4,
		MD_MVCC = 4'd5,
		MD_END = 4'd6,
		MD_ABORT = 4'd7,
		MD_ACTIVE = 4'd8,
		MD_READ = 4'd9,
		MD_BEGIN = 4'd10,
		MD_COMPLETE = 4'd11
	} mode_t;

	typedef struct packed {
		logic [MODE_W-1:0] mode;
		logic [SLOT_W-1:0] slot;
		logic [STAMP_W-1:0] stamp_a;
		logic [STAMP_W-1:0] stamp_b;
		logic [TXN_W-1:0] txn_id;
	} req_t;

	typedef struct packed {
		logic proceed;
		logic conflict;
		logic active;
		logic signed [WIDE_W-1:0] start_low;
		logic [STAMP_W-1:0] start_high;
		logic [STAMP_W-1:0] commit_low;
		logic signed [WIDE_W-1:0] start_pick;
		logic [STAMP_W-1:0] commit_val;
	} rsp_t;

	// classified request as handed from the front end to the back end
	typedef struct packed {
		mode_t op;
		logic in_range;
		logic [SLOT_W-1:0] slot;
		logic [STAMP_W-1:0] stamp_a;
		logic [STAMP_W-1:0] stamp_a_dec;
		logic [STAMP_W-1:0] stamp_b;
		logic [TXN_W-1:0] txn_id;
	} cmd_t;

	typedef struct packed {
		logic [TXN_W-1:0] txn;
		logic [STAMP_W-1:0] start_low;
		logic [STAMP_W-1:0] start_high;
		logic [STAMP_W-1:0] commit_low;
		logic [STAMP_W-1:0] commit;
		logic completing;
	} rec_t;

	localparam rec_t REC_RESET = '{
		txn: '0,
		start_low: '0,
		start_high: STAMP_TOP,
		commit_low: '0,
		commit: '0,
		completing: 1'b0
	};

	typedef enum logic {
		BK_RD = 1'b0,
		BK_EX = 1'b1
	} bk_state_t;

endpackage

// ===== hdl/tti_if.sv =====
// Valid/ready channel interfaces for the request and response sides.
// Depends on tti_pkg for the payload types.
interface tti_req_if import tti_pkg::*; ();
	logic valid;
	logic ready;
	req_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

interface tti_rsp_if import tti_pkg::*; ();
	logic valid;
	logic ready;
	rsp_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

// ===== hdl/tti_front.sv =====
// Front end: takes requests, classifies mode and slot range, pushes commands.
// Depends on tti_pkg and tti_req_if.
module tti_front import tti_pkg::*; #(
	parameter int SLOTS = 64
) (
	tti_req_if.sink req,
	input logic q_full,
	output logic push,
	output cmd_t push_cmd
);

	mode_t op;

	always_comb begin
		unique case (req.data.mode)
			MD_UPD_START, MD_UPD_COMMIT, MD_FORCE_HIGH, MD_FORCE_CLOW,
			MD_CONFLICT, MD_MVCC, MD_END, MD_ABORT, MD_ACTIVE, MD_READ,
			MD_BEGIN, MD_COMPLETE: op = mode_t'(req.data.mode);
			default: op = MD_READ; // unused codes behave as a read
		endcase
	end

	assign req.ready = !q_full;
	assign push = req.valid && !q_full;

	always_comb begin
		push_cmd.op = op;
		push_cmd.in_range = (32'(req.data.slot) < 32'(SLOTS));
		push_cmd.slot = req.data.slot;
		push_cmd.stamp_a = req.data.stamp_a;
		push_cmd.stamp_a_dec = req.data.stamp_a - STAMP_W'(1);
		push_cmd.stamp_b = req.data.stamp_b;
		push_cmd.txn_id = req.data.txn_id;
	end

endmodule

// ===== hdl/tti_queue.sv =====
// Short command queue between front and back end.
// Depends on tti_pkg.
module tti_queue import tti_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic push,
	input cmd_t push_cmd,
	output logic full,
	input logic pop,
	output cmd_t pop_cmd,
	output logic empty
);

	localparam int PTR_W = $clog2(QUEUE_DEPTH);
	localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

	cmd_t entry_q [QUEUE_DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;

	assign full = (count_q == CNT_W'(QUEUE_DEPTH));
	assign empty = (count_q == '0);
	assign pop_cmd = entry_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= push_cmd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + PTR_W'(1);
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + PTR_W'(1);
			end
			unique case ({push, pop})
				2'b10: count_q <= count_q + CNT_W'(1);
				2'b01: count_q <= count_q - CNT_W'(1);
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

// ===== hdl/tti_back.sv =====
// Back end: slot record memory, read-modify-write per command, response register.
// Depends on tti_pkg and tti_rsp_if.
module tti_back import tti_pkg::*; #(
	parameter int SLOTS = 64
) (
	input logic clk,
	input logic arst_n,
	input logic q_empty,
	input cmd_t q_cmd,
	output logic pop,
	tti_rsp_if.source rsp
);

	localparam int IDX_W = $clog2(SLOTS);
	localparam int REC_W = $bits(rec_t);

	bk_state_t state_q, state_d;
	logic ex_go;

	logic [REC_W-1:0] mem [SLOTS];
	logic [SLOTS-1:0] valid_q;
	logic [REC_W-1:0] rd_data_q;
	logic rd_valid_q;
	cmd_t cmd_q;

	logic [IDX_W-1:0] rd_idx;
	logic [IDX_W-1:0] wr_idx;
	rec_t cur, nxt;
	rsp_t res;
	logic rsp_valid_q;
	rsp_t rsp_data_q;

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			BK_RD: if (!q_empty) state_d = BK_EX;
			BK_EX: if (ex_go) state_d = BK_RD;
			default: state_d = BK_RD;
		endcase
	end

	// outputs
	always_comb begin
		pop = 1'b0;
		ex_go = 1'b0;
		unique case (state_q)
			BK_RD: pop = !q_empty;
			BK_EX: ex_go = !rsp_valid_q || rsp.ready;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= BK_RD;
		end else begin
			state_q <= state_d;
		end
	end

	assign rd_idx = IDX_W'(q_cmd.slot);
	assign wr_idx = IDX_W'(cmd_q.slot);

	// memory: one write, one registered read
	always_ff @(posedge clk) begin
		if (ex_go && cmd_q.in_range) begin
			mem[wr_idx] <= nxt;
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			rd_data_q <= mem[rd_idx];
			rd_valid_q <= valid_q[rd_idx];
			cmd_q <= q_cmd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
		end else if (ex_go && cmd_q.in_range) begin
			valid_q[wr_idx] <= 1'b1;
		end
	end

	// never-written slots read as reset records
	assign cur = rd_valid_q ? rec_t'(rd_data_q) : REC_RESET;

	always_comb begin
		nxt = cur;
		res = '0;
		unique case (cmd_q.op)
			MD_UPD_START: begin
				if (cur.txn == '0) begin
					res.proceed = 1'b1;
				end else if (cur.completing) begin
					res.proceed = (cur.start_high < cmd_q.stamp_a);
				end else if (cmd_q.stamp_a > cur.start_low) begin
					if (cmd_q.stamp_a_dec < cur.start_high) nxt.start_high = cmd_q.stamp_a_dec;
					res.proceed = 1'b1;
				end
			end
			MD_UPD_COMMIT: begin
				if (cur.txn == '0) begin
					res.proceed = 1'b1;
				end else if (cur.completing) begin
					res.proceed = (cur.commit > cmd_q.stamp_a);
				end else begin
					if (cmd_q.stamp_a > cur.commit_low) nxt.commit_low = cmd_q.stamp_a;
					res.proceed = 1'b1;
				end
			end
			MD_FORCE_HIGH: begin
				if (cur.start_low < cmd_q.stamp_a) begin
					if (cur.start_high > cmd_q.stamp_a) nxt.start_high = cmd_q.stamp_a;
					res.proceed = 1'b1;
				end
			end
			MD_FORCE_CLOW: begin
				if (cmd_q.stamp_a > cur.commit_low) nxt.commit_low = cmd_q.stamp_a;
				res.proceed = 1'b1;
			end
			MD_CONFLICT: res.conflict = !(cmd_q.stamp_a > cur.start_low);
			MD_MVCC: begin
				if (cur.start_low < cmd_q.stamp_a) nxt.start_low = cmd_q.stamp_a;
				if (cur.commit_low < cmd_q.stamp_b) nxt.commit_low = cmd_q.stamp_b;
			end
			MD_END: nxt = REC_RESET;
			MD_ABORT: nxt.txn = '0;
			MD_ACTIVE: res.active = (cur.txn == cmd_q.txn_id);
			MD_BEGIN: begin
				nxt = REC_RESET;
				nxt.txn = cmd_q.txn_id;
			end
			MD_COMPLETE: begin
				nxt.commit = cmd_q.stamp_a;
				nxt.completing = 1'b1;
			end
			default: ;
		endcase

		if (cmd_q.op == MD_ACTIVE) begin
			if (res.active && nxt.completing) begin
				res.start_low = {1'b0, nxt.start_low};
				res.commit_val = nxt.commit;
			end else begin
				res.start_low = NEG_ONE;
				res.commit_val = '0;
			end
		end else begin
			res.start_low = (nxt.start_low == '0) ? NEG_ONE : {1'b0, nxt.start_low};
			res.commit_val = nxt.completing ? nxt.commit : '0;
		end

		if (nxt.txn == '0) begin
			res.start_pick = NEG_ONE;
		end else if (nxt.start_high != STAMP_TOP) begin
			res.start_pick = {1'b0, nxt.start_high};
		end else if (nxt.start_low > (STAMP_TOP - PICK_STEP)) begin
			res.start_pick = {1'b0, STAMP_TOP};
		end else begin
			res.start_pick = {1'b0, nxt.start_low + PICK_STEP};
		end

		res.start_high = nxt.start_high;
		res.commit_low = nxt.commit_low;

		if (!cmd_q.in_range) begin
			res = '0;
			res.start_low = NEG_ONE;
			res.start_pick = NEG_ONE;
		end
	end

	always_ff @(posedge clk) begin
		if (ex_go) begin
			rsp_data_q <= res;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (ex_go) begin
			rsp_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			rsp_valid_q <= 1'b0;
		end
	end

	assign rsp.valid = rsp_valid_q;
	assign rsp.data = rsp_data_q;

endmodule

// ===== hdl/txn_timestamp_interval_table_unit.sv =====
// Transaction timestamp interval table: per-slot start/commit interval records
// updated by clamp rules, one response per request. In the back end each
// request first has its slot record read from the single-port slot memory
// into a register, then the mode is applied, the record written back and the
// response register loaded; that last step waits while an untaken response is
// held, and the next request is read only after it. A two-entry command queue
// lets requests be accepted while the back end works or while a response waits
// to be taken. All slots start in the end-of-transaction state straight out of
// reset, with no clearing pass. Slot numbers at or beyond SLOTS return the
// fixed "invalid slot" response and change nothing.
// Depends on tti_pkg, tti_if, tti_front, tti_queue and tti_back.
module txn_timestamp_interval_table_unit import tti_pkg::*; #(
	parameter int SLOTS = 64
) (
	input logic clk,
	input logic arst_n,
	tti_req_if.sink req,
	tti_rsp_if.source rsp
);

	logic q_full;
	logic q_empty;
	logic push;
	logic pop;
	cmd_t push_cmd;
	cmd_t pop_cmd;

	// decode mode, flag out-of-range slots, precompute stamp_a - 1
	tti_front #(
		.SLOTS(SLOTS)
	) u_front (
		.req(req),
		.q_full(q_full),
		.push(push),
		.push_cmd(push_cmd)
	);

	// decouples request acceptance from record processing
	tti_queue u_queue (
		.clk(clk),
		.arst_n(arst_n),
		.push(push),
		.push_cmd(push_cmd),
		.full(q_full),
		.pop(pop),
		.pop_cmd(pop_cmd),
		.empty(q_empty)
	);

	// read-modify-write of the slot record, response register
	tti_back #(
		.SLOTS(SLOTS)
	) u_back (
		.clk(clk),
		.arst_n(arst_n),
		.q_empty(q_empty),
		.q_cmd(pop_cmd),
		.pop(pop),
		.rsp(rsp)
	);

endmodule
